### hw/rtl/ircfpe_pkg.sv
// Shared types, constants and helper functions for the IR climate frame pulse encoder.
// Used by the channel interfaces and all encoder modules.
package ircfpe_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 19;
  localparam int PIDX_W      = 9;
  localparam int BYTE_IX_W   = 5;
  localparam logic [PIDX_W-1:0] TOTAL_PULSES = PIDX_W'(2 + FRAME_BYTES * 16 + 2);

  // Variable frame bytes live in a small command RAM: mode, temperature, fan.
  localparam int MEM_DEPTH = 3;
  localparam int MEM_AW    = 2;
  localparam logic [BYTE_IX_W-1:0] VAR_FIRST = BYTE_IX_W'(5);
  localparam logic [BYTE_IX_W-1:0] VAR_LAST  = BYTE_IX_W'(10);

  // Field widths
  localparam int DUR_W   = 16;
  localparam int CFG_IX_W = 3;

  // Request opcodes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Command field codes
  localparam logic [2:0] MODE_HEAT    = 3'd4;
  localparam logic [2:0] SPEED_HIGH   = 3'd4;
  localparam logic [1:0] STATUS_ECON  = 2'd1;
  localparam logic [1:0] STATUS_POWER = 2'd2;
  localparam logic [7:0] ECON_BYTE    = 8'h06;
  localparam logic [7:0] TEMP_BASE    = 8'd17;

  // Configuration register indexes
  typedef enum logic [CFG_IX_W-1:0] {
    REG_ANNOUNCE_MARK = 3'd0,
    REG_ZERO_SPACE    = 3'd1,
    REG_ONE_SPACE     = 3'd2,
    REG_START_MARK    = 3'd3,
    REG_START_SPACE   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [DUR_W-1:0] announce_mark;
    logic [DUR_W-1:0] zero_space;
    logic [DUR_W-1:0] one_space;
    logic [DUR_W-1:0] start_mark;
    logic [DUR_W-1:0] start_space;
  } cfg_regs_t;

  // Kind of pulse a request produces
  typedef enum logic [2:0] {
    PK_NONE,
    PK_START_MARK,
    PK_START_SPACE,
    PK_ANNOUNCE,
    PK_DATA_SPACE,
    PK_END_SPACE
  } pulse_kind_e;

  // Decoded request carried from the sequencer to the output stage
  typedef struct packed {
    pulse_kind_e kind;
    logic [7:0]  hdr_byte;
    logic        use_mem;
    logic        mem_inv;
    logic [2:0]  bit_ix;
  } stage_t;

  // Base (uncomplemented) variable bytes of a command
  typedef struct packed {
    logic [7:0] fan_byte;
    logic [7:0] temp_byte;
    logic [7:0] mode_byte;
  } cmd_bytes_t;

  typedef struct packed {
    logic       en;
    cmd_bytes_t bytes;
  } cmd_wr_t;

  // Fixed header bytes; variable positions read as zero here
  function automatic logic [7:0] header_byte(input logic [BYTE_IX_W-1:0] ix);
    logic [7:0] b;
    unique case (ix)
      5'd0:    b = 8'h52;
      5'd1:    b = 8'hAE;
      5'd2:    b = 8'hC3;
      5'd3:    b = 8'h1A;
      5'd4:    b = 8'hE5;
      5'd11:   b = 8'h3F;
      5'd12:   b = 8'hC0;
      5'd13:   b = 8'h37;
      5'd14:   b = 8'hC8;
      5'd15:   b = 8'hFF;
      5'd17:   b = 8'h7F;
      5'd18:   b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Build the three base bytes from a command; out-of-range codes fall back to auto/normal
  function automatic cmd_bytes_t build_cmd(input logic       power_off,
                                           input logic [2:0] mode,
                                           input logic [4:0] temp_c,
                                           input logic [1:0] status,
                                           input logic [2:0] fan_speed);
    cmd_bytes_t c;
    logic [2:0] m;
    logic [2:0] s;
    m = (mode > MODE_HEAT) ? 3'd0 : mode;
    s = (fan_speed > SPEED_HIGH) ? 3'd0 : fan_speed;
    c.mode_byte = {4'b0000, ~power_off, m};
    c.temp_byte = {3'b000, temp_c} - TEMP_BASE;
    priority if (status == STATUS_ECON) begin
      c.fan_byte = ECON_BYTE;
    end else if (status == STATUS_POWER) begin
      c.fan_byte = {4'b0000, 1'b1, s};
    end else begin
      c.fan_byte = {5'b00000, s};
    end
    return c;
  endfunction

endpackage

### hw/rtl/ircfpe_if.sv
// Valid/ready channel interfaces: command requests, pulse results, register writes.
// Depends on ircfpe_pkg for field widths.
interface ircfpe_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic       power_off;
  logic [2:0] mode;
  logic [4:0] temp_c;
  logic [1:0] status;
  logic [2:0] fan_speed;

  modport source (output valid, op, power_off, mode, temp_c, status, fan_speed,
                  input ready);
  modport sink   (input valid, op, power_off, mode, temp_c, status, fan_speed,
                  output ready);
endinterface

interface ircfpe_pulse_if;
  logic                          valid;
  logic                          ready;
  logic                          pulse_valid;
  logic                          led_on;
  logic [ircfpe_pkg::DUR_W-1:0]  duration_us;
  logic                          last_pulse;

  modport source (output valid, pulse_valid, led_on, duration_us, last_pulse,
                  input ready);
  modport sink   (input valid, pulse_valid, led_on, duration_us, last_pulse,
                  output ready);
endinterface

interface ircfpe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ircfpe_pkg::CFG_IX_W-1:0] index;
  logic [ircfpe_pkg::DUR_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/ir_climate_frame_pulse_encoder_core.sv
// IR climate remote frame pulse encoder, top level.
// Instantiates the timing registers, pulse sequencer and command RAM; depends on
// ircfpe_pkg and the channel interfaces in ircfpe_if.sv.
//
// Usage:
//   req  - requests: op 0 loads a command (mode, temperature, status, fan) and
//          restarts the frame; op 1 asks for the next mark or space.
//   rsp  - one result per request: pulse_valid, led_on, duration_us, last_pulse.
//          Loads and requests while no frame is active return all zeros.
//   cfg  - timing register writes (index, data), always ready; write only while
//          the block is idle.
//   A frame is 308 pulses: start mark/space, 152 bit pairs LSB first, then a
//   final announce mark and a zero-length space flagged last_pulse.
//   Throughput: one request per cycle while rsp is taken. A result passes the
//   decode stage, then the output register that also takes the command RAM
//   read data, before it is on rsp.
//   Reset: timing registers return to defaults and the encoder goes idle; the
//   command RAM is not cleared, since no frame can start without a load.
//   Stall: while rsp is not taken the result holds, one more request is held in
//   the decode stage, and req.ready then drops.
module ir_climate_frame_pulse_encoder_core (
  input  logic          clk,
  input  logic          rst,
  ircfpe_req_if.sink    req,
  ircfpe_pulse_if.source rsp,
  ircfpe_cfg_if.sink    cfg
);

  ircfpe_pkg::cfg_regs_t           regs;
  ircfpe_pkg::stage_t              s1;
  ircfpe_pkg::cmd_wr_t             cmd_wr;
  logic                            s1_valid;
  logic                            out_free;
  logic                            rd_en;
  logic [ircfpe_pkg::MEM_AW-1:0]   rd_addr;
  logic [7:0]                      rd_data;
  logic [7:0]                      byte_val;
  logic                            data_bit;
  logic                            led_next;
  logic                            last_next;
  logic [ircfpe_pkg::DUR_W-1:0]    dur_next;

  logic                            out_valid;
  logic                            out_pulse_valid;
  logic                            out_led_on;
  logic [ircfpe_pkg::DUR_W-1:0]    out_duration;
  logic                            out_last;

  ircfpe_cfg_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ircfpe_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .out_free (out_free),
    .s1_valid (s1_valid),
    .s1       (s1),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .cmd_wr   (cmd_wr)
  );

  ircfpe_frame_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .cmd_wr  (cmd_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register is free when empty or being taken
  assign out_free = !out_valid || rsp.ready;

  // Frame byte for this bit: header constant or RAM byte, complemented where needed
  assign byte_val = s1.use_mem ? (s1.mem_inv ? ~rd_data : rd_data) : s1.hdr_byte;
  assign data_bit = byte_val[s1.bit_ix];

  // Result fields by pulse kind
  always_comb begin
    led_next  = 1'b0;
    last_next = 1'b0;
    dur_next  = '0;
    unique case (s1.kind)
      ircfpe_pkg::PK_START_MARK: begin
        led_next = 1'b1;
        dur_next = regs.start_mark;
      end
      ircfpe_pkg::PK_START_SPACE: begin
        dur_next = regs.start_space;
      end
      ircfpe_pkg::PK_ANNOUNCE: begin
        led_next = 1'b1;
        dur_next = regs.announce_mark;
      end
      ircfpe_pkg::PK_DATA_SPACE: begin
        dur_next = data_bit ? regs.one_space : regs.zero_space;
      end
      ircfpe_pkg::PK_END_SPACE: begin
        last_next = 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_pulse_valid <= (s1.kind != ircfpe_pkg::PK_NONE);
      out_led_on      <= led_next;
      out_duration    <= dur_next;
      out_last        <= last_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.pulse_valid = out_pulse_valid;
  assign rsp.led_on      = out_led_on;
  assign rsp.duration_us = out_duration;
  assign rsp.last_pulse  = out_last;

endmodule

### hw/rtl/ircfpe_cfg_regs.sv
// Pulse timing register file, written over the configuration channel.
// Depends on ircfpe_pkg and ircfpe_cfg_if.
module ircfpe_cfg_regs (
  input  logic                   clk,
  input  logic                   rst,
  ircfpe_cfg_if.sink             cfg,
  output ircfpe_pkg::cfg_regs_t  regs
);

  // Writes are always accepted, taking effect at the next clock edge
  assign cfg.ready = 1'b1;

  // Register update; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.announce_mark <= 16'd375;
      regs.zero_space    <= 16'd400;
      regs.one_space     <= 16'd1190;
      regs.start_mark    <= 16'd3180;
      regs.start_space   <= 16'd1580;
    end else if (cfg.valid) begin
      unique case (ircfpe_pkg::cfg_reg_e'(cfg.index))
        ircfpe_pkg::REG_ANNOUNCE_MARK: regs.announce_mark <= cfg.data;
        ircfpe_pkg::REG_ZERO_SPACE:    regs.zero_space    <= cfg.data;
        ircfpe_pkg::REG_ONE_SPACE:     regs.one_space     <= cfg.data;
        ircfpe_pkg::REG_START_MARK:    regs.start_mark    <= cfg.data;
        ircfpe_pkg::REG_START_SPACE:   regs.start_space   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/ircfpe_frame_mem.sv
// Command RAM holding the mode, temperature and fan bytes, with a write sequencer
// that stores a loaded command one byte per cycle. Depends on ircfpe_pkg.
module ircfpe_frame_mem (
  input  logic                                clk,
  input  logic                                rst,
  input  ircfpe_pkg::cmd_wr_t                 cmd_wr,
  input  logic                                rd_en,
  input  logic [ircfpe_pkg::MEM_AW-1:0]       rd_addr,
  output logic [7:0]                          rd_data
);

  logic [7:0]                     mem [ircfpe_pkg::MEM_DEPTH];
  ircfpe_pkg::cmd_bytes_t         pend;
  logic                           wr_busy;
  logic [ircfpe_pkg::MEM_AW-1:0]  wr_ptr;
  logic [7:0]                     wr_byte;

  // Byte for the current write slot
  always_comb begin
    unique case (wr_ptr)
      2'd0:    wr_byte = pend.mode_byte;
      2'd1:    wr_byte = pend.temp_byte;
      default: wr_byte = pend.fan_byte;
    endcase
  end

  // Write sequencer: a new load restarts it from slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_busy <= 1'b0;
      wr_ptr  <= '0;
    end else if (cmd_wr.en) begin
      wr_busy <= 1'b1;
      wr_ptr  <= '0;
    end else if (wr_busy) begin
      wr_busy <= (wr_ptr != ircfpe_pkg::MEM_AW'(ircfpe_pkg::MEM_DEPTH - 1));
      wr_ptr  <= wr_ptr + ircfpe_pkg::MEM_AW'(1);
    end
  end

  // Pending command bytes
  always_ff @(posedge clk) begin
    if (cmd_wr.en) begin
      pend <= cmd_wr.bytes;
    end
  end

  // RAM write port; a variable byte is first read 84 requests after a load,
  // long after the three writes have landed
  always_ff @(posedge clk) begin
    if (wr_busy && !cmd_wr.en) begin
      mem[wr_ptr] <= wr_byte;
    end
  end

  // RAM read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_load_starts_writer: assert property (@(posedge clk) disable iff (rst)
    cmd_wr.en |=> (wr_busy && wr_ptr == '0))
    else $error("write sequencer did not restart on load");

  a_wr_ptr_range: assert property (@(posedge clk) disable iff (rst)
    wr_busy |-> (wr_ptr <= ircfpe_pkg::MEM_AW'(ircfpe_pkg::MEM_DEPTH - 1)))
    else $error("write pointer beyond command RAM");
`endif

endmodule

### hw/rtl/ircfpe_seq.sv
// Pulse sequencer: pulse index and frame-active flag, request decode, RAM read
// issue and the decoded request stage. Depends on ircfpe_pkg and ircfpe_req_if.
module ircfpe_seq (
  input  logic                           clk,
  input  logic                           rst,
  ircfpe_req_if.sink                     req,
  input  logic                           out_free,
  output logic                           s1_valid,
  output ircfpe_pkg::stage_t             s1,
  output logic                           rd_en,
  output logic [ircfpe_pkg::MEM_AW-1:0]  rd_addr,
  output ircfpe_pkg::cmd_wr_t            cmd_wr
);

  logic [ircfpe_pkg::PIDX_W-1:0]    pulse_index;
  logic [ircfpe_pkg::PIDX_W-1:0]    pulse_index_next;
  logic                             sending;
  logic                             sending_next;
  logic                             accept;
  logic [ircfpe_pkg::PIDX_W-1:0]    k;
  logic [ircfpe_pkg::BYTE_IX_W-1:0] byte_ix;
  logic [ircfpe_pkg::BYTE_IX_W-1:0] offset;
  logic                             at_end;
  ircfpe_pkg::stage_t               s0;

  // Handshake: take a request when the stage is empty or drains this cycle
  assign req.ready = !s1_valid || out_free;
  assign accept    = req.valid && req.ready;

  // Bit position of the current data pulse pair
  assign k       = pulse_index - ircfpe_pkg::PIDX_W'(2);
  assign byte_ix = k[ircfpe_pkg::BYTE_IX_W+3:4];
  assign offset  = byte_ix - ircfpe_pkg::VAR_FIRST;
  assign at_end  = (pulse_index == ircfpe_pkg::TOTAL_PULSES - ircfpe_pkg::PIDX_W'(1));

  // Decode the request against the current position
  always_comb begin
    s0.kind     = ircfpe_pkg::PK_NONE;
    s0.hdr_byte = ircfpe_pkg::header_byte(byte_ix);
    s0.use_mem  = (byte_ix >= ircfpe_pkg::VAR_FIRST) && (byte_ix <= ircfpe_pkg::VAR_LAST);
    s0.mem_inv  = ~offset[0];
    s0.bit_ix   = k[3:1];
    pulse_index_next = pulse_index;
    sending_next     = sending;
    if (req.op == ircfpe_pkg::OP_LOAD) begin
      pulse_index_next = '0;
      sending_next     = 1'b1;
    end else if (sending) begin
      priority if (pulse_index == '0) begin
        s0.kind = ircfpe_pkg::PK_START_MARK;
      end else if (pulse_index == ircfpe_pkg::PIDX_W'(1)) begin
        s0.kind = ircfpe_pkg::PK_START_SPACE;
      end else if (pulse_index == ircfpe_pkg::TOTAL_PULSES - ircfpe_pkg::PIDX_W'(2)) begin
        s0.kind = ircfpe_pkg::PK_ANNOUNCE;
      end else if (at_end) begin
        s0.kind = ircfpe_pkg::PK_END_SPACE;
      end else if (k[0]) begin
        s0.kind = ircfpe_pkg::PK_DATA_SPACE;
      end else begin
        s0.kind = ircfpe_pkg::PK_ANNOUNCE;
      end
      pulse_index_next = at_end ? '0 : pulse_index + ircfpe_pkg::PIDX_W'(1);
      sending_next     = !at_end;
    end
  end

  // RAM read for data spaces that fall in the variable bytes
  assign rd_en   = accept && (s0.kind == ircfpe_pkg::PK_DATA_SPACE) && s0.use_mem;
  assign rd_addr = offset[ircfpe_pkg::MEM_AW:1];

  // Command bytes to the RAM on a load
  assign cmd_wr.en    = accept && (req.op == ircfpe_pkg::OP_LOAD);
  assign cmd_wr.bytes = ircfpe_pkg::build_cmd(req.power_off, req.mode, req.temp_c,
                                              req.status, req.fan_speed);

  // Position state
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_index <= '0;
      sending     <= 1'b0;
    end else if (accept) begin
      pulse_index <= pulse_index_next;
      sending     <= sending_next;
    end
  end

  // Decoded request stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s0;
    end
  end

`ifndef SYNTHESIS
  a_idle_index_zero: assert property (@(posedge clk) disable iff (rst)
    !sending |-> (pulse_index == '0))
    else $error("pulse index nonzero while idle");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    pulse_index < ircfpe_pkg::TOTAL_PULSES)
    else $error("pulse index past end of frame");
`endif

endmodule

### sim/ir_climate_frame_pulse_encoder_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the IR climate frame pulse encoder: random and directed requests,
// an in-bench frame/pulse predictor and result comparison under random idling and stalls.
// Depends on ircfpe_pkg, the channel interfaces and ir_climate_frame_pulse_encoder_core.
module ir_climate_frame_pulse_encoder_core_test;
  import ircfpe_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 280;
  localparam int MAX_PRINTS  = 30;

  typedef struct packed {
    logic       op;
    logic       power_off;
    logic [2:0] mode;
    logic [4:0] temp_c;
    logic [1:0] status;
    logic [2:0] fan_speed;
  } cmd_req_t;

  typedef struct packed {
    logic             pulse_valid;
    logic             led_on;
    logic [DUR_W-1:0] duration_us;
    logic             last_pulse;
  } pulse_t;

  logic clk;
  logic rst;

  ircfpe_req_if   req_ch();
  ircfpe_pulse_if rsp_ch();
  ircfpe_cfg_if   cfg_ch();

  ir_climate_frame_pulse_encoder_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Predictor state: frame image, position in the pulse train, timing registers
  logic [7:0]        frame_img [FRAME_BYTES];
  logic [PIDX_W-1:0] pulse_pos;
  logic              frame_active;
  cfg_regs_t         timing;

  cmd_req_t cmd_backlog [$];
  pulse_t   expected_pulses [$];
  cmd_req_t drive_cmd;
  pulse_t   want_pulse;
  logic     holding;

  int unsigned reqs_queued;
  int unsigned reqs_accepted;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Work out the result of one accepted request and advance the frame state
  task automatic encode_pulse(input cmd_req_t r);
    pulse_t      p;
    logic [2:0]  m;
    logic [2:0]  s;
    logic [7:0]  mb;
    logic [7:0]  fb;
    int unsigned k;
    int unsigned bitn;
    p = '0;
    if (r.op == OP_LOAD) begin
      m  = (r.mode > MODE_HEAT) ? 3'd0 : r.mode;
      s  = (r.fan_speed > SPEED_HIGH) ? 3'd0 : r.fan_speed;
      mb = r.power_off ? {5'd0, m} : 8'd8 + {5'd0, m};
      if (r.status == STATUS_ECON) begin
        fb = ECON_BYTE;
      end else if (r.status == STATUS_POWER) begin
        fb = 8'd8 + {5'd0, s};
      end else begin
        fb = {5'd0, s};
      end
      frame_img[6]  = mb;
      frame_img[5]  = ~mb;
      frame_img[8]  = {3'd0, r.temp_c} - TEMP_BASE;
      frame_img[7]  = ~frame_img[8];
      frame_img[10] = fb;
      frame_img[9]  = ~fb;
      pulse_pos     = '0;
      frame_active  = 1'b1;
    end else if (frame_active && pulse_pos < TOTAL_PULSES) begin
      p.pulse_valid = 1'b1;
      if (pulse_pos == 0) begin
        p.led_on      = 1'b1;
        p.duration_us = timing.start_mark;
      end else if (pulse_pos == 1) begin
        p.duration_us = timing.start_space;
      end else if (pulse_pos == TOTAL_PULSES - 2) begin
        p.led_on      = 1'b1;
        p.duration_us = timing.announce_mark;
      end else if (pulse_pos == TOTAL_PULSES - 1) begin
        p.last_pulse = 1'b1;
      end else begin
        // data bits go LSB first, each an announce mark then its space
        k = pulse_pos - 2;
        if (k % 2 == 0) begin
          p.led_on      = 1'b1;
          p.duration_us = timing.announce_mark;
        end else begin
          bitn = k / 2;
          p.duration_us = frame_img[bitn / 8][bitn % 8] ? timing.one_space : timing.zero_space;
        end
      end
      pulse_pos = pulse_pos + PIDX_W'(1);
      if (pulse_pos >= TOTAL_PULSES) begin
        pulse_pos    = '0;
        frame_active = 1'b0;
      end
    end else begin
      frame_active = 1'b0;
    end
    expected_pulses.push_back(p);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      holding = req_ch.valid && !req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        encode_pulse(drive_cmd);
        reqs_accepted++;
      end
      if (!holding) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          drive_cmd = cmd_backlog.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.op        <= drive_cmd.op;
          req_ch.power_off <= drive_cmd.power_off;
          req_ch.mode      <= drive_cmd.mode;
          req_ch.temp_c    <= drive_cmd.temp_c;
          req_ch.status    <= drive_cmd.status;
          req_ch.fan_speed <= drive_cmd.fan_speed;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_pulses.size() == 0) begin
          report_mismatch("result arrived with none outstanding");
        end else begin
          want_pulse = expected_pulses.pop_front();
          if (rsp_ch.pulse_valid !== want_pulse.pulse_valid)
            report_mismatch($sformatf("pulse_valid %b, want %b",
                                      rsp_ch.pulse_valid, want_pulse.pulse_valid));
          if (rsp_ch.led_on !== want_pulse.led_on)
            report_mismatch($sformatf("led_on %b, want %b",
                                      rsp_ch.led_on, want_pulse.led_on));
          if (rsp_ch.duration_us !== want_pulse.duration_us)
            report_mismatch($sformatf("duration_us %0d, want %0d",
                                      rsp_ch.duration_us, want_pulse.duration_us));
          if (rsp_ch.last_pulse !== want_pulse.last_pulse)
            report_mismatch($sformatf("last_pulse %b, want %b",
                                      rsp_ch.last_pulse, want_pulse.last_pulse));
        end
      end
      rsp_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  task automatic queue_cmd(input logic op, input logic off, input logic [2:0] mode,
                           input logic [4:0] temp, input logic [1:0] status,
                           input logic [2:0] fan);
    cmd_req_t c;
    c.op        = op;
    c.power_off = off;
    c.mode      = mode;
    c.temp_c    = temp;
    c.status    = status;
    c.fan_speed = fan;
    cmd_backlog.push_back(c);
    reqs_queued++;
  endtask

  task automatic queue_random(input logic op);
    queue_cmd(op, 1'($urandom), 3'($urandom), 5'($urandom), 2'($urandom), 3'($urandom));
  endtask

  // Mostly whole frames with random commands; some aborted by a new load, some noise
  task automatic queue_random_block(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    int unsigned room;
    start = reqs_queued;
    while (reqs_queued - start < target) begin
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
        queue_random(1'($urandom));
      end else begin
        // keep the block at its target; the last frame may be cut short
        room = target - (reqs_queued - start) - 1;
        n = (pick < 65) ? TOTAL_PULSES + $urandom_range(3, 0) : $urandom_range(TOTAL_PULSES - 1, 1);
        if (n > room) n = room;
        queue_random(OP_LOAD);
        repeat (n) queue_random(OP_ADVANCE);
      end
    end
  endtask

  task automatic write_timing(input cfg_reg_e ix, input logic [DUR_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= ix;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    case (ix)
      REG_ANNOUNCE_MARK: timing.announce_mark = val;
      REG_ZERO_SPACE:    timing.zero_space    = val;
      REG_ONE_SPACE:     timing.one_space     = val;
      REG_START_MARK:    timing.start_mark    = val;
      REG_START_SPACE:   timing.start_space   = val;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_all_timing(input logic [DUR_W-1:0] am, input logic [DUR_W-1:0] zs,
                                  input logic [DUR_W-1:0] os, input logic [DUR_W-1:0] sm,
                                  input logic [DUR_W-1:0] ss);
    write_timing(REG_ANNOUNCE_MARK, am);
    write_timing(REG_ZERO_SPACE, zs);
    write_timing(REG_ONE_SPACE, os);
    write_timing(REG_START_MARK, sm);
    write_timing(REG_START_SPACE, ss);
  endtask

  task automatic wait_drained();
    while (reqs_accepted != reqs_queued || expected_pulses.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.op        = OP_LOAD;
    req_ch.power_off = 1'b0;
    req_ch.mode      = '0;
    req_ch.temp_c    = '0;
    req_ch.status    = '0;
    req_ch.fan_speed = '0;
    rsp_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_ANNOUNCE_MARK;
    cfg_ch.data      = '0;
    cycle_count      = 0;
    reqs_queued      = 0;
    reqs_accepted    = 0;
    mismatch_count   = 0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    // predictor after reset
    frame_img = '{8'h52, 8'hAE, 8'hC3, 8'h1A, 8'hE5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h3F, 8'hC0, 8'h37, 8'hC8, 8'hFF, 8'h00, 8'h7F, 8'h80};
    pulse_pos    = '0;
    frame_active = 1'b0;
    timing.announce_mark = 16'd375;
    timing.zero_space    = 16'd400;
    timing.one_space     = 16'd1190;
    timing.start_mark    = 16'd3180;
    timing.start_space   = 16'd1580;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: advance while idle, field extremes, out-of-range codes, reloads mid-frame
    queue_cmd(OP_ADVANCE, 1'b0, 3'd0, 5'd0, 2'd0, 3'd0);
    queue_cmd(OP_ADVANCE, 1'b1, 3'd7, 5'd31, 2'd3, 3'd7);
    queue_cmd(OP_LOAD, 1'b0, MODE_HEAT, 5'd31, STATUS_POWER, SPEED_HIGH);
    repeat (4) queue_cmd(OP_ADVANCE, 1'b0, 3'd0, 5'd0, 2'd0, 3'd0);
    queue_cmd(OP_LOAD, 1'b1, 3'd7, 5'd0, 2'd3, 3'd7);
    repeat (3) queue_cmd(OP_ADVANCE, 1'b1, 3'd7, 5'd31, 2'd3, 3'd7);
    queue_cmd(OP_LOAD, 1'b0, 3'd5, 5'd16, STATUS_ECON, 3'd5);
    queue_cmd(OP_ADVANCE, 1'b0, 3'd0, 5'd0, 2'd0, 3'd0);
    queue_cmd(OP_LOAD, 1'b1, 3'd0, 5'd17, 2'd0, 3'd0);
    queue_cmd(OP_ADVANCE, 1'b0, 3'd0, 5'd0, 2'd0, 3'd0);
    queue_cmd(OP_LOAD, 1'b0, 3'd6, 5'd18, STATUS_POWER, 3'd6);
    queue_cmd(OP_LOAD, 1'b1, MODE_HEAT, 5'd30, STATUS_ECON, 3'd3);
    repeat (3) queue_cmd(OP_ADVANCE, 1'b0, 3'd0, 5'd0, 2'd0, 3'd0);
    wait_drained();

    // Random phases, each with its own timing setting and idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_all_timing(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom));
        1: write_all_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: write_all_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        default: write_all_timing(16'd1, 16'hFFFF, 16'h0000, 16'h8000, 16'($urandom));
      endcase
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      queue_random_block(PHASE_ITEMS);
      wait_drained();
    end

    // let any stray result show up
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ircfpe_pkg.sv
hw/rtl/ircfpe_if.sv
hw/rtl/ircfpe_cfg_regs.sv
hw/rtl/ircfpe_frame_mem.sv
hw/rtl/ircfpe_seq.sv
hw/rtl/ir_climate_frame_pulse_encoder_core.sv
sim/ir_climate_frame_pulse_encoder_core_test.sv
